/* design/pal_pkg.sv */
// Shared types and constants for the positional array list.
`default_nettype none

package pal_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CAP_W = 5;
  localparam int POS_W = 4;
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int WORD_W = 32;

  typedef enum logic [2:0] {
    ACT_APPEND = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_DELETE = 3'd2,
    ACT_SEARCH = 3'd3,
    ACT_CLEAR  = 3'd4
  } act_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_APPEND,
    CMD_INSERT,
    CMD_DELETE,
    CMD_CLEAR
  } cmd_t;

  typedef struct packed {
    logic [2:0]               action;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic       ok;
    logic       found;
    logic [3:0] found_index;
    logic [4:0] entry_count;
  } rsp_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    cmd_t                     cmd;
    logic [IDX_W-1:0]         pos;
    logic [CNT_W-1:0]         count;
    logic signed [WORD_W-1:0] value;
  } pal_ctl_t;

endpackage

`default_nettype wire

/* design/pal_cell.sv */
// One slot of the list: holds a word, shifts with its neighbors, compares.
`default_nettype none

module pal_cell (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire pal_pkg::pal_ctl_t                ctl,
  input  wire logic [pal_pkg::IDX_W-1:0]        index,
  input  wire logic signed [pal_pkg::WORD_W-1:0] left,
  input  wire logic signed [pal_pkg::WORD_W-1:0] right,
  output logic signed [pal_pkg::WORD_W-1:0]      entry,
  output logic                                  match
);
  import pal_pkg::*;

  logic signed [WORD_W-1:0] entry_next;
  logic                     below_count;

  assign below_count = CNT_W'(index) < ctl.count;
  assign match = below_count && (entry == ctl.value);

  always_comb begin
    entry_next = entry;
    case (ctl.cmd)
      CMD_APPEND: begin
        if (index == ctl.pos) entry_next = ctl.value;
      end
      CMD_INSERT: begin
        if (index == ctl.pos) entry_next = ctl.value;
        else if (index > ctl.pos) entry_next = left;
      end
      // slots at or above the count hold zero, so pulling from the right
      // zeroes the freed slot
      CMD_DELETE: begin
        if (index >= ctl.pos) entry_next = right;
      end
      CMD_CLEAR: entry_next = '0;
      default: entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else begin
      entry <= entry_next;
    end
  end

  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    !below_count |-> entry == '0)
    else $error("slot above the count is not zero");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    ctl.cmd == CMD_CLEAR |=> entry == '0)
    else $error("slot not zeroed by clear");

  a_no_match_above: assert property (@(posedge clk) disable iff (rst)
    match |-> below_count)
    else $error("match reported above the count");

endmodule

`default_nettype wire

/* design/positional_array_list.sv */
// Top level of the positional array list.
// Ordered list of up to DEPTH (16) signed 32-bit words held in a chain of
// cells, one word per cell. Every operation (append, insert, delete, search,
// clear) is carried out by all cells together: they shift or compare all slots at
// once and the result lands in an output register, so a new request is taken
// every cycle while the response side keeps up. The capacity register
// (reset 15) limits appends and inserts; a value above DEPTH acts as DEPTH.
// Reset zeroes all slots and the count.
`default_nettype none

module positional_array_list (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [pal_pkg::CAP_W-1:0]   cfg_data,
  input  wire logic                        req_valid,
  output logic                             req_ready,
  input  wire pal_pkg::req_t               req,
  output logic                             rsp_valid,
  input  wire logic                        rsp_ready,
  output pal_pkg::rsp_t                    rsp
);
  import pal_pkg::*;

  logic [CAP_W-1:0]                capacity;
  logic [CNT_W-1:0]                count;
  logic [CNT_W-1:0]                count_next;
  logic [DEPTH-1:0][WORD_W-1:0]    words;
  logic [DEPTH-1:0]                slot_hits;
  pal_ctl_t                        ctl;
  rsp_t                            rsp_next;
  logic                            accept;
  logic                            has_room;
  logic                            pos_valid;
  logic                            hit;
  logic [IDX_W-1:0]                hit_index;

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;

  assign has_room  = (CMP_W'(count) < CMP_W'(capacity)) && (CMP_W'(count) < CMP_W'(DEPTH));
  assign pos_valid = CMP_W'(req.position) < CMP_W'(count);

  // lowest matching slot wins
  always_comb begin
    hit       = 1'b0;
    hit_index = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (slot_hits[i]) begin
        hit       = 1'b1;
        hit_index = IDX_W'(i);
      end
    end
  end

  always_comb begin
    ctl.cmd   = CMD_NONE;
    ctl.pos   = IDX_W'(req.position);
    ctl.count = count;
    ctl.value = req.value;
    count_next = count;
    rsp_next = '0;
    case (act_t'(req.action))
      ACT_APPEND: begin
        if (has_room) begin
          ctl.cmd    = CMD_APPEND;
          ctl.pos    = IDX_W'(count);
          count_next = count + CNT_W'(1);
          rsp_next.ok = 1'b1;
        end
      end
      ACT_INSERT: begin
        if (has_room && pos_valid) begin
          ctl.cmd    = CMD_INSERT;
          count_next = count + CNT_W'(1);
          rsp_next.ok = 1'b1;
        end
      end
      ACT_DELETE: begin
        if (pos_valid) begin
          ctl.cmd    = CMD_DELETE;
          count_next = count - CNT_W'(1);
          rsp_next.ok = 1'b1;
        end
      end
      ACT_SEARCH: begin
        rsp_next.found       = hit;
        rsp_next.found_index = 4'(hit_index);
      end
      ACT_CLEAR: begin
        ctl.cmd    = CMD_CLEAR;
        count_next = '0;
      end
      default: ;
    endcase
    rsp_next.entry_count = 5'(count_next);
    // hold the chain when nothing is transferred
    if (!accept) ctl.cmd = CMD_NONE;
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [WORD_W-1:0] left_word;
      logic signed [WORD_W-1:0] right_word;
      if (g == 0) begin : g_first
        assign left_word = '0;
      end else begin : g_mid_l
        assign left_word = words[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign right_word = '0;
      end else begin : g_mid_r
        assign right_word = words[g+1];
      end
      pal_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .ctl   (ctl),
        .index (IDX_W'(g)),
        .left  (left_word),
        .right (right_word),
        .entry (words[g]),
        .match (slot_hits[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAP_W'(15);
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) capacity <= cfg_data;
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) rsp <= rsp_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(count) <= CMP_W'(DEPTH))
    else $error("count beyond store depth");

  a_count_reported: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp.entry_count == 5'(count))
    else $error("reported count differs from held count");

  a_ok_found_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.ok && rsp.found))
    else $error("ok and found both set");

  a_found_in_list: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.found) |-> (5'(rsp.found_index) < rsp.entry_count))
    else $error("found index outside the list");

endmodule

`default_nettype wire

/* bench/positional_array_list_tb.sv */
// Self-checking bench: list operations against a predictor across capacity settings.
module positional_array_list_tb;
  import pal_pkg::*;

  localparam logic [2:0] ACT_RSVD_FIRST = 3'd5;
  localparam logic [2:0] ACT_RSVD_MID   = 3'd6;
  localparam logic [2:0] ACT_RSVD_LAST  = 3'd7;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 150;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    req_t stim;
    bit   typed;
    rsp_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_data = '0;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  positional_array_list dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always #1 clk = ~clk;

  // Predicted list contents, fill level and capacity
  logic signed [WORD_W-1:0] slot_q [DEPTH];
  int unsigned used = 0;
  int unsigned cap_q = 15;

  rsp_t list_results_q [$];
  dir_row_t dir_table [$];
  int unsigned cap_plan [PHASES] = '{15, 16, 1, 31, 0, 9, 3, 16, 12};

  int unsigned send_gap_pct = 0;
  int unsigned recv_gap_pct = 0;
  bit row_typed = 1'b0;
  rsp_t row_want = '0;
  int stall_cycles = 0;
  int fail_count = 0;
  int req_count = 0;
  int edit_count = 0;
  int hit_count = 0;
  int full_count = 0;

  function automatic rsp_t list_apply(input req_t r);
    rsp_t o;
    int unsigned lim;
    int unsigned p;
    o = '0;
    lim = (cap_q < DEPTH) ? cap_q : DEPTH;
    p = r.position;
    case (r.action)
      ACT_APPEND: begin
        if (used < lim) begin
          slot_q[used] = r.value;
          used++;
          o.ok = 1'b1;
        end
      end
      ACT_INSERT: begin
        if (used < lim && p < used) begin
          for (int i = used; i > p; i--) slot_q[i] = slot_q[i-1];
          slot_q[p] = r.value;
          used++;
          o.ok = 1'b1;
        end
      end
      ACT_DELETE: begin
        if (p < used) begin
          for (int i = p; i + 1 < used; i++) slot_q[i] = slot_q[i+1];
          used--;
          slot_q[used] = '0;
          o.ok = 1'b1;
        end
      end
      ACT_SEARCH: begin
        for (int i = 0; i < used; i++) begin
          if (slot_q[i] == r.value) begin
            o.found = 1'b1;
            o.found_index = 4'(i);
            break;
          end
        end
      end
      ACT_CLEAR: begin
        slot_q = '{default: '0};
        used = 0;
      end
      default: ;
    endcase
    o.entry_count = 5'(used);
    return o;
  endfunction

  function automatic req_t draw_req();
    req_t r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 32) r.action = ACT_APPEND;
    else if (pick < 56) r.action = ACT_INSERT;
    else if (pick < 76) r.action = ACT_DELETE;
    else if (pick < 92) r.action = ACT_SEARCH;
    else if (pick < 94) r.action = ACT_CLEAR;
    else r.action = 3'($urandom_range(ACT_RSVD_FIRST, ACT_RSVD_LAST));
    // aim most positions inside the list so inserts and deletes land
    if (used > 0 && $urandom_range(0, 9) < 8) r.position = 4'($urandom_range(0, used - 1));
    else r.position = 4'($urandom);
    case ($urandom_range(0, 9))
      4, 5: r.value = 32'($urandom_range(0, 3));
      6: begin
        case ($urandom_range(0, 3))
          0: r.value = 32'h7FFF_FFFF;
          1: r.value = 32'h8000_0000;
          2: r.value = 32'hFFFF_FFFF;
          default: r.value = '0;
        endcase
      end
      7, 8, 9: begin
        if (used > 0) r.value = slot_q[$urandom_range(0, used - 1)];
        else r.value = 32'($urandom);
      end
      default: r.value = 32'($urandom);
    endcase
    return r;
  endfunction

  function automatic dir_row_t mk(input logic [2:0] a, input logic [3:0] p,
                                  input logic [31:0] v, input bit t, input bit ok,
                                  input bit fd, input logic [3:0] ix,
                                  input logic [4:0] cn);
    dir_row_t row;
    row.stim = '{action: a, position: p, value: v};
    row.typed = t;
    row.want = '{ok: ok, found: fd, found_index: ix, entry_count: cn};
    return row;
  endfunction

  task automatic check_field(input string name, input logic [4:0] want, input logic [4:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic send_item(input req_t item, input bit typed, input rsp_t want);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req <= item;
    row_typed = typed;
    row_want = want;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_ready !== 1'b1);
    @(negedge clk);
  endtask

  always @(negedge clk) rsp_ready <= ($urandom_range(0, 99) >= recv_gap_pct);

  always @(posedge clk) begin
    rsp_t want;
    rsp_t pred;
    bit moved;
    moved = 1'b0;
    if (!rst) begin
      if (req_valid && req_ready) begin
        moved = 1'b1;
        pred = list_apply(req);
        list_results_q.push_back(row_typed ? row_want : pred);
        req_count++;
      end
      if (rsp_valid && rsp_ready) begin
        moved = 1'b1;
        if (list_results_q.size() == 0) begin
          $error("result transfer with nothing outstanding");
          fail_count++;
        end else begin
          want = list_results_q.pop_front();
          check_field("ok", 5'(want.ok), 5'(rsp.ok));
          check_field("found", 5'(want.found), 5'(rsp.found));
          check_field("found_index", 5'(want.found_index), 5'(rsp.found_index));
          check_field("entry_count", want.entry_count, rsp.entry_count);
          if (rsp.ok) edit_count++;
          if (rsp.found) hit_count++;
          if (rsp.entry_count == 5'(DEPTH)) full_count++;
        end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
    end
  end

  initial begin
    do @(negedge clk); while (stall_cycles < STALL_LIMIT);
    $display("positional_array_list: mismatch");
    $finish;
  end

  initial begin
    slot_q = '{default: '0};
    dir_table = '{
      mk(ACT_SEARCH, 4'd0, 32'h0000_0000, 1, 0, 0, 4'd0, 5'd0),
      mk(ACT_INSERT, 4'd0, 32'h0000_0001, 1, 0, 0, 4'd0, 5'd0),
      mk(ACT_DELETE, 4'd0, 32'h0000_0000, 1, 0, 0, 4'd0, 5'd0),
      mk(ACT_APPEND, 4'd0, 32'h7FFF_FFFF, 1, 1, 0, 4'd0, 5'd1),
      mk(ACT_APPEND, 4'd15, 32'h8000_0000, 1, 1, 0, 4'd0, 5'd2),
      mk(ACT_APPEND, 4'd0, 32'hFFFF_FFFF, 1, 1, 0, 4'd0, 5'd3),
      mk(ACT_SEARCH, 4'd0, 32'hFFFF_FFFF, 1, 0, 1, 4'd2, 5'd3),
      mk(ACT_INSERT, 4'd0, 32'h0000_0000, 1, 1, 0, 4'd0, 5'd4),
      mk(ACT_INSERT, 4'd4, 32'h0000_0005, 1, 0, 0, 4'd0, 5'd4),
      mk(ACT_INSERT, 4'd15, 32'h0000_0005, 1, 0, 0, 4'd0, 5'd4),
      mk(ACT_SEARCH, 4'd0, 32'h0000_0000, 1, 0, 1, 4'd0, 5'd4),
      mk(ACT_DELETE, 4'd15, 32'h0000_0000, 1, 0, 0, 4'd0, 5'd4),
      mk(ACT_DELETE, 4'd3, 32'h0000_0000, 1, 1, 0, 4'd0, 5'd3),
      mk(ACT_SEARCH, 4'd0, 32'hFFFF_FFFF, 1, 0, 0, 4'd0, 5'd3),
      mk(ACT_SEARCH, 4'd0, 32'h8000_0000, 1, 0, 1, 4'd2, 5'd3),
      mk(ACT_RSVD_FIRST, 4'd15, 32'hFFFF_FFFF, 1, 0, 0, 4'd0, 5'd3),
      mk(ACT_RSVD_MID, 4'd0, 32'h0000_0000, 1, 0, 0, 4'd0, 5'd3),
      mk(ACT_RSVD_LAST, 4'd7, 32'hAAAA_AAAA, 1, 0, 0, 4'd0, 5'd3),
      mk(ACT_INSERT, 4'd1, 32'h5555_5555, 0, 0, 0, 4'd0, 5'd0),
      mk(ACT_INSERT, 4'd3, 32'hAAAA_AAAA, 0, 0, 0, 4'd0, 5'd0),
      mk(ACT_DELETE, 4'd0, 32'h0000_0000, 0, 0, 0, 4'd0, 5'd0),
      mk(ACT_SEARCH, 4'd0, 32'hAAAA_AAAA, 0, 0, 0, 4'd0, 5'd0),
      mk(ACT_CLEAR, 4'd0, 32'hFFFF_FFFF, 1, 0, 0, 4'd0, 5'd0),
      mk(ACT_SEARCH, 4'd0, 32'h0000_0000, 1, 0, 0, 4'd0, 5'd0)
    };

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int ph = 0; ph < PHASES; ph++) begin
      send_gap_pct = (ph < 3) ? 10 : (ph < 6) ? 52 : 0;
      recv_gap_pct = (ph < 3) ? 52 : (ph < 6) ? 10 : 0;
      if (ph > 0) begin
        // hold off until the list is quiet, then change capacity
        req_valid <= 1'b0;
        while (list_results_q.size() != 0) @(negedge clk);
        repeat (3) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= CAP_W'(cap_plan[ph]);
        @(negedge clk);
        cfg_we <= 1'b0;
        cap_q = cap_plan[ph];
      end
      if (ph == 0)
        foreach (dir_table[i]) send_item(dir_table[i].stim, dir_table[i].typed, dir_table[i].want);
      repeat (PHASE_ITEMS) send_item(draw_req(), 1'b0, '0);
    end

    req_valid <= 1'b0;
    while (list_results_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Ran %0d requests over %0d capacity settings, including zero and oversize.",
             req_count, PHASES);
    $display("%0d edits succeeded, %0d searches hit, %0d results at a full store.",
             edit_count, hit_count, full_count);
    if (fail_count == 0) begin
      $display("positional_array_list: match");
    end else begin
      $display("positional_array_list: mismatch");
    end
    $finish;
  end

endmodule
